FILE: design/lbcm_pkg.sv
// ----------------------------------------------------------------------------
// LED blink current monitor package
// Shared constants, codes, configuration and control types for the monitor.
// ----------------------------------------------------------------------------
package lbcm_pkg;

  localparam int RING_DEPTH = 16;
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int LOOKBACK = 7;

  localparam int SAMPLE_W = 12;
  localparam int CUR_W = 15;
  localparam int ACC_W = 18;
  localparam int MAG_W = 16;
  localparam int QUO3_W = 15;
  localparam int INDEX_W = 24;
  localparam int BLINK_W = 16;
  localparam int PEAK_W = 14;
  localparam int PSUM_W = 32;
  localparam int STBY_W = 24;
  localparam int LED_W = 11;
  localparam int DELTA_W = 10;
  localparam int NLED_W = 5;
  localparam int LIMIT_W = 23;
  localparam int VERDICT_W = 3;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int READ_TAPS = 5;
  localparam int DIV_STEPS = PSUM_W;
  localparam int CNT_W = 5;

  localparam int RECIP3_SHIFT = 17;
  localparam logic [MAG_W-1:0] RECIP3 = 16'd43691;
  localparam int LED_ROUND = 32;
  localparam int LED_SHIFT = 6;

  localparam logic [DELTA_W-1:0] DELTA_DEFAULT = 10'd15;
  localparam logic [DELTA_W-1:0] DELTA_RESET = 10'd15;
  localparam logic [NLED_W-1:0] NLED_RESET = 5'd17;
  localparam logic [PEAK_W-1:0] MIN_PEAK_RESET = 14'd30;
  localparam logic [PEAK_W-1:0] MAX_PEAK_RESET = 14'd100;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd200;

  localparam logic [2:0] TAP_PREV = 3'd0;
  localparam logic [2:0] TAP_NEXT = 3'd1;
  localparam logic [2:0] TAP_OLD_PREV = 3'd2;
  localparam logic [2:0] TAP_OLD = 3'd3;
  localparam logic [2:0] TAP_OLD_NEXT = 3'd4;

  typedef enum logic [1:0] {
    MODE_TEST    = 2'd0,
    MODE_STANDBY = 2'd1,
    MODE_FINISH  = 2'd2
  } mode_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_PASS        = 3'd0,
    VERDICT_UNDERPOWER  = 3'd1,
    VERDICT_NO_BOOT     = 3'd2,
    VERDICT_MISSING_LED = 3'd3,
    VERDICT_OVERPOWER   = 3'd4,
    VERDICT_STANDBY     = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    REG_DELTA         = 3'd0,
    REG_CHARGER_SCALE = 3'd1,
    REG_EXPECTED_LEDS = 3'd2,
    REG_MIN_PEAK      = 3'd3,
    REG_MAX_PEAK      = 3'd4,
    REG_STANDBY_LIMIT = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_READ,
    ST_SCALE,
    ST_EDGE,
    ST_STANDBY,
    ST_DIVIDE,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta_ma;
    logic               charger_scale;
    logic [NLED_W-1:0]  expected_leds;
    logic [PEAK_W-1:0]  min_peak_ma;
    logic [PEAK_W-1:0]  max_peak_ma;
    logic [LIMIT_W-1:0] standby_limit;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       sample_write;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       acc_en;
    logic [2:0] acc_sel;
    logic       scale;
    logic       edge_apply;
    logic       stby_add;
    logic       div_init;
    logic       div_step;
    logic       report_load;
  } cmd_t;

  typedef struct packed {
    logic window;
    logic out_free;
  } stat_t;

  function automatic logic [RING_AW-1:0] tap_offset(input logic [2:0] sel);
    logic [RING_AW-1:0] off;
    case (sel)
      TAP_PREV:     off = RING_AW'(RING_DEPTH - 1);
      TAP_NEXT:     off = RING_AW'(1);
      TAP_OLD_PREV: off = RING_AW'(RING_DEPTH - LOOKBACK - 1);
      TAP_OLD:      off = RING_AW'(RING_DEPTH - LOOKBACK);
      TAP_OLD_NEXT: off = RING_AW'(RING_DEPTH - LOOKBACK + 1);
      default:      off = '0;
    endcase
    return off;
  endfunction

  function automatic logic tap_subtract(input logic [2:0] sel);
    return (sel != TAP_PREV) && (sel != TAP_NEXT);
  endfunction

endpackage

FILE: design/lbcm_meas_if.sv
// ----------------------------------------------------------------------------
// Measurement channel
// Valid/ready channel that carries one current measurement item.
// ----------------------------------------------------------------------------
interface lbcm_meas_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            mode;
  logic signed [lbcm_pkg::SAMPLE_W-1:0]  current_sample;

  modport source (output valid, output mode, output current_sample, input ready);
  modport sink (input valid, input mode, input current_sample, output ready);
endinterface

FILE: design/lbcm_report_if.sv
// ----------------------------------------------------------------------------
// Report channel
// Valid/ready channel that carries one evaluation report item.
// ----------------------------------------------------------------------------
interface lbcm_report_if;
  logic                                valid;
  logic                                ready;
  logic [lbcm_pkg::VERDICT_W-1:0]      verdict;
  logic [lbcm_pkg::LED_W-1:0]          led_count;
  logic [lbcm_pkg::BLINK_W-1:0]        blink_count;
  logic [lbcm_pkg::PEAK_W-1:0]         average_peak;
  logic signed [lbcm_pkg::STBY_W-1:0]  standby_total;
  logic [lbcm_pkg::INDEX_W-1:0]        samples_seen;

  modport source (output valid, output verdict, output led_count, output blink_count,
                  output average_peak, output standby_total, output samples_seen,
                  input ready);
  modport sink (input valid, input verdict, input led_count, input blink_count,
                input average_peak, input standby_total, input samples_seen,
                output ready);
endinterface

FILE: design/led_blink_current_monitor.sv
// ----------------------------------------------------------------------------
// LED blink current monitor
// Counts LED blinks from supply-current samples and evaluates a unit.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A standby sample passes through the
// standby step before the next item can be taken. A self-test sample goes
// through the sample and edge steps while the ring is filling, and adds five
// ring reads through the single read port and the divide-by-3 multiply once
// 16 samples are in. A finish item runs the one bit per cycle divider for the
// average peak, plus any wait for the previous report to be taken. The report
// sits in an output register, so new samples are accepted while it waits.
// Configuration is written through the APB port with no wait states and
// should only change while the block is idle.
module led_blink_current_monitor (
  input  logic                           clk,
  input  logic                           rst,
  lbcm_meas_if.sink                      meas,
  lbcm_report_if.source                  report,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lbcm_pkg::ADDR_W-1:0]    paddr,
  input  logic [lbcm_pkg::DATA_W-1:0]    pwdata,
  output logic [lbcm_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  lbcm_pkg::cfg_t   cfg;
  lbcm_pkg::cmd_t   cmd;
  lbcm_pkg::stat_t  stat;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delta_ma      <= lbcm_pkg::DELTA_RESET;
      cfg.charger_scale <= 1'b0;
      cfg.expected_leds <= lbcm_pkg::NLED_RESET;
      cfg.min_peak_ma   <= lbcm_pkg::MIN_PEAK_RESET;
      cfg.max_peak_ma   <= lbcm_pkg::MAX_PEAK_RESET;
      cfg.standby_limit <= lbcm_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (paddr[4:2])
        lbcm_pkg::REG_DELTA:         cfg.delta_ma <= pwdata[lbcm_pkg::DELTA_W-1:0];
        lbcm_pkg::REG_CHARGER_SCALE: cfg.charger_scale <= pwdata[0];
        lbcm_pkg::REG_EXPECTED_LEDS: cfg.expected_leds <= pwdata[lbcm_pkg::NLED_W-1:0];
        lbcm_pkg::REG_MIN_PEAK:      cfg.min_peak_ma <= pwdata[lbcm_pkg::PEAK_W-1:0];
        lbcm_pkg::REG_MAX_PEAK:      cfg.max_peak_ma <= pwdata[lbcm_pkg::PEAK_W-1:0];
        lbcm_pkg::REG_STANDBY_LIMIT: cfg.standby_limit <= pwdata[lbcm_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      lbcm_pkg::REG_DELTA:         prdata = lbcm_pkg::DATA_W'(cfg.delta_ma);
      lbcm_pkg::REG_CHARGER_SCALE: prdata = lbcm_pkg::DATA_W'(cfg.charger_scale);
      lbcm_pkg::REG_EXPECTED_LEDS: prdata = lbcm_pkg::DATA_W'(cfg.expected_leds);
      lbcm_pkg::REG_MIN_PEAK:      prdata = lbcm_pkg::DATA_W'(cfg.min_peak_ma);
      lbcm_pkg::REG_MAX_PEAK:      prdata = lbcm_pkg::DATA_W'(cfg.max_peak_ma);
      lbcm_pkg::REG_STANDBY_LIMIT: prdata = lbcm_pkg::DATA_W'(cfg.standby_limit);
      default:                     prdata = '0;
    endcase
  end

  lbcm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas.valid),
    .mode       (meas.mode),
    .meas_ready (meas.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lbcm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg            (cfg),
    .current_sample (meas.current_sample),
    .report_ready   (report.ready),
    .report_valid   (report.valid),
    .verdict        (report.verdict),
    .led_count      (report.led_count),
    .blink_count    (report.blink_count),
    .average_peak   (report.average_peak),
    .standby_total  (report.standby_total),
    .samples_seen   (report.samples_seen)
  );

endmodule

FILE: design/lbcm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/lbcm_ctrl.sv
// ----------------------------------------------------------------------------
// Monitor controller
// Sequences each item through the sample, tap read, scaling and edge steps,
// the standby step, or the divide and report steps of the datapath.
// ----------------------------------------------------------------------------
module lbcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                meas_valid,
  input  logic [1:0]          mode,
  output logic                meas_ready,
  input  lbcm_pkg::stat_t     stat,
  output lbcm_pkg::cmd_t      cmd
);

  lbcm_pkg::state_t            state, state_next;
  logic [lbcm_pkg::CNT_W-1:0]  cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbcm_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lbcm_pkg::ST_IDLE: begin
        if (meas_valid) begin
          case (mode)
            lbcm_pkg::MODE_TEST:    state_next = lbcm_pkg::ST_SAMPLE;
            lbcm_pkg::MODE_STANDBY: state_next = lbcm_pkg::ST_STANDBY;
            lbcm_pkg::MODE_FINISH:  state_next = lbcm_pkg::ST_DIVIDE;
            default:                state_next = lbcm_pkg::ST_IDLE;
          endcase
        end
      end
      lbcm_pkg::ST_SAMPLE: begin
        state_next = stat.window ? lbcm_pkg::ST_READ : lbcm_pkg::ST_EDGE;
      end
      lbcm_pkg::ST_READ: begin
        if (cnt == lbcm_pkg::CNT_W'(lbcm_pkg::READ_TAPS)) begin
          state_next = lbcm_pkg::ST_SCALE;
        end
      end
      lbcm_pkg::ST_SCALE:   state_next = lbcm_pkg::ST_EDGE;
      lbcm_pkg::ST_EDGE:    state_next = lbcm_pkg::ST_IDLE;
      lbcm_pkg::ST_STANDBY: state_next = lbcm_pkg::ST_IDLE;
      lbcm_pkg::ST_DIVIDE: begin
        if (cnt == lbcm_pkg::CNT_W'(lbcm_pkg::DIV_STEPS - 1)) begin
          state_next = lbcm_pkg::ST_REPORT;
        end
      end
      lbcm_pkg::ST_REPORT: begin
        if (stat.out_free) begin
          state_next = lbcm_pkg::ST_IDLE;
        end
      end
      default: state_next = lbcm_pkg::ST_IDLE;
    endcase
  end

  assign cnt_next = (state_next == state) ? cnt + 1'b1 : '0;

  always_comb begin
    meas_ready = 1'b0;
    cmd        = '0;
    case (state)
      lbcm_pkg::ST_IDLE: begin
        meas_ready   = 1'b1;
        cmd.capture  = meas_valid;
        cmd.div_init = meas_valid && (mode == lbcm_pkg::MODE_FINISH);
      end
      lbcm_pkg::ST_SAMPLE: cmd.sample_write = 1'b1;
      lbcm_pkg::ST_READ: begin
        cmd.rd_en   = cnt < lbcm_pkg::CNT_W'(lbcm_pkg::READ_TAPS);
        cmd.rd_sel  = cnt[2:0];
        cmd.acc_en  = cnt != '0;
        cmd.acc_sel = cnt[2:0] - 3'd1;
      end
      lbcm_pkg::ST_SCALE:   cmd.scale = 1'b1;
      lbcm_pkg::ST_EDGE:    cmd.edge_apply = 1'b1;
      lbcm_pkg::ST_STANDBY: cmd.stby_add = 1'b1;
      lbcm_pkg::ST_DIVIDE:  cmd.div_step = 1'b1;
      lbcm_pkg::ST_REPORT:  cmd.report_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: design/lbcm_datapath.sv
// ----------------------------------------------------------------------------
// Monitor datapath
// Sample ring, filtered difference, blink and peak tracking, standby sum,
// peak average divider and the report register.
// ----------------------------------------------------------------------------
module lbcm_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lbcm_pkg::cmd_t                        cmd,
  output lbcm_pkg::stat_t                       stat,
  input  lbcm_pkg::cfg_t                        cfg,
  input  logic signed [lbcm_pkg::SAMPLE_W-1:0]  current_sample,
  input  logic                                  report_ready,
  output logic                                  report_valid,
  output logic [lbcm_pkg::VERDICT_W-1:0]        verdict,
  output logic [lbcm_pkg::LED_W-1:0]            led_count,
  output logic [lbcm_pkg::BLINK_W-1:0]          blink_count,
  output logic [lbcm_pkg::PEAK_W-1:0]           average_peak,
  output logic signed [lbcm_pkg::STBY_W-1:0]    standby_total,
  output logic [lbcm_pkg::INDEX_W-1:0]          samples_seen
);

  logic signed [lbcm_pkg::SAMPLE_W-1:0]  sample_r;
  logic signed [lbcm_pkg::CUR_W-1:0]     cur_ext, cur;
  logic [lbcm_pkg::RING_AW-1:0]          ring_raddr;
  logic [lbcm_pkg::CUR_W-1:0]            ring_rdata;
  logic signed [lbcm_pkg::ACC_W-1:0]     ring_ext, acc;
  logic [lbcm_pkg::MAG_W-1:0]            mag;
  logic [2*lbcm_pkg::MAG_W-1:0]          prod;
  logic [lbcm_pkg::QUO3_W-1:0]           q_mag;
  logic                                  q_neg;
  logic [lbcm_pkg::DELTA_W-1:0]          delta_eff;
  logic                                  q_gt, rise, fall;

  logic [lbcm_pkg::INDEX_W-1:0]          sample_index;
  logic                                  led_on;
  logic [lbcm_pkg::BLINK_W-1:0]          blinks;
  logic [lbcm_pkg::PEAK_W-1:0]           peak_now;
  logic [lbcm_pkg::PSUM_W-1:0]           peak_sum;
  logic signed [lbcm_pkg::STBY_W-1:0]    standby_sum;
  logic [lbcm_pkg::PSUM_W:0]             psum_ext;
  logic signed [lbcm_pkg::STBY_W:0]      stby_ext;

  logic [lbcm_pkg::BLINK_W-1:0]          rem;
  logic [lbcm_pkg::PSUM_W-1:0]           quo;
  logic [lbcm_pkg::BLINK_W:0]            div_shift;
  logic                                  div_ge;

  logic [lbcm_pkg::BLINK_W:0]            led_sum;
  logic [lbcm_pkg::LED_W-1:0]            leds;
  logic [lbcm_pkg::PEAK_W-1:0]           avg;
  logic                                  stby_over;
  lbcm_pkg::verdict_t                    verdict_calc, verdict_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= current_sample;
    end
  end

  assign cur_ext = lbcm_pkg::CUR_W'(sample_r);
  assign cur     = cfg.charger_scale ? (cur_ext <<< 2) + cur_ext : cur_ext;

  assign ring_raddr = sample_index[lbcm_pkg::RING_AW-1:0] + lbcm_pkg::tap_offset(cmd.rd_sel);

  lbcm_ram #(
    .WIDTH (lbcm_pkg::CUR_W),
    .DEPTH (lbcm_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.sample_write),
    .waddr (sample_index[lbcm_pkg::RING_AW-1:0]),
    .wdata (cur),
    .re    (cmd.rd_en),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign ring_ext = lbcm_pkg::ACC_W'($signed(ring_rdata));
  assign mag      = acc[lbcm_pkg::ACC_W-1] ? lbcm_pkg::MAG_W'(-acc) : lbcm_pkg::MAG_W'(acc);
  assign prod     = mag * lbcm_pkg::RECIP3;

  always_ff @(posedge clk) begin
    if (cmd.sample_write) begin
      acc   <= lbcm_pkg::ACC_W'(cur);
      q_mag <= '0;
      q_neg <= 1'b0;
    end else if (cmd.acc_en) begin
      if (lbcm_pkg::tap_subtract(cmd.acc_sel)) begin
        acc <= acc - ring_ext;
      end else begin
        acc <= acc + ring_ext;
      end
    end else if (cmd.scale) begin
      q_mag <= prod[2*lbcm_pkg::MAG_W-1:lbcm_pkg::RECIP3_SHIFT];
      q_neg <= acc[lbcm_pkg::ACC_W-1];
    end
  end

  assign delta_eff = (cfg.delta_ma == '0) ? lbcm_pkg::DELTA_DEFAULT : cfg.delta_ma;
  assign q_gt      = q_mag > lbcm_pkg::QUO3_W'(delta_eff);
  assign rise      = cmd.edge_apply && !q_neg && q_gt && !led_on;
  assign fall      = cmd.edge_apply && q_neg && q_gt && led_on;

  assign psum_ext = {1'b0, peak_sum} + (lbcm_pkg::PSUM_W + 1)'(peak_now);
  assign stby_ext = (lbcm_pkg::STBY_W + 1)'(standby_sum) + (lbcm_pkg::STBY_W + 1)'(sample_r);

  always_ff @(posedge clk) begin
    if (rst || cmd.report_load) begin
      sample_index <= '0;
      led_on       <= 1'b0;
      blinks       <= '0;
      peak_now     <= '0;
      peak_sum     <= '0;
      standby_sum  <= '0;
    end else begin
      if (cmd.sample_write && !cur[lbcm_pkg::CUR_W-1]
          && (cur[lbcm_pkg::PEAK_W-1:0] > peak_now)) begin
        peak_now <= cur[lbcm_pkg::PEAK_W-1:0];
      end
      if (rise) begin
        led_on <= 1'b1;
        if (blinks != '1) begin
          blinks <= blinks + 1'b1;
        end
      end
      if (fall) begin
        led_on   <= 1'b0;
        peak_now <= '0;
        peak_sum <= psum_ext[lbcm_pkg::PSUM_W] ? '1 : psum_ext[lbcm_pkg::PSUM_W-1:0];
      end
      if (cmd.edge_apply && (sample_index != '1)) begin
        sample_index <= sample_index + 1'b1;
      end
      if (cmd.stby_add) begin
        if (stby_ext[lbcm_pkg::STBY_W] != stby_ext[lbcm_pkg::STBY_W-1]) begin
          standby_sum <= stby_ext[lbcm_pkg::STBY_W]
                         ? {1'b1, {(lbcm_pkg::STBY_W-1){1'b0}}}
                         : {1'b0, {(lbcm_pkg::STBY_W-1){1'b1}}};
        end else begin
          standby_sum <= stby_ext[lbcm_pkg::STBY_W-1:0];
        end
      end
    end
  end

  assign div_shift = {rem, quo[lbcm_pkg::PSUM_W-1]};
  assign div_ge    = div_shift >= {1'b0, blinks};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      quo <= peak_sum;
    end else if (cmd.div_step) begin
      if (div_ge) begin
        rem <= lbcm_pkg::BLINK_W'(div_shift - {1'b0, blinks});
      end else begin
        rem <= div_shift[lbcm_pkg::BLINK_W-1:0];
      end
      quo <= {quo[lbcm_pkg::PSUM_W-2:0], div_ge};
    end
  end

  assign led_sum = {1'b0, blinks} + (lbcm_pkg::BLINK_W + 1)'(lbcm_pkg::LED_ROUND);
  assign leds    = lbcm_pkg::LED_W'(led_sum >> lbcm_pkg::LED_SHIFT);

  always_comb begin
    if (blinks == '0) begin
      avg = '0;
    end else if (quo[lbcm_pkg::PSUM_W-1:lbcm_pkg::PEAK_W] != '0) begin
      avg = '1;
    end else begin
      avg = quo[lbcm_pkg::PEAK_W-1:0];
    end
  end

  assign stby_over = !standby_sum[lbcm_pkg::STBY_W-1]
                     && (standby_sum[lbcm_pkg::STBY_W-2:0] > cfg.standby_limit);

  always_comb begin
    if (avg < cfg.min_peak_ma) begin
      verdict_calc = lbcm_pkg::VERDICT_UNDERPOWER;
    end else if (leds == '0) begin
      verdict_calc = lbcm_pkg::VERDICT_NO_BOOT;
    end else if (leds != lbcm_pkg::LED_W'(cfg.expected_leds)) begin
      verdict_calc = lbcm_pkg::VERDICT_MISSING_LED;
    end else if (avg > cfg.max_peak_ma) begin
      verdict_calc = lbcm_pkg::VERDICT_OVERPOWER;
    end else if (stby_over) begin
      verdict_calc = lbcm_pkg::VERDICT_STANDBY;
    end else begin
      verdict_calc = lbcm_pkg::VERDICT_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (cmd.report_load) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report_load) begin
      verdict_r     <= verdict_calc;
      led_count     <= leds;
      blink_count   <= blinks;
      average_peak  <= avg;
      standby_total <= standby_sum;
      samples_seen  <= sample_index;
    end
  end

  assign verdict       = verdict_r;
  assign stat.window   = sample_index[lbcm_pkg::INDEX_W-1:lbcm_pkg::RING_AW] != '0;
  assign stat.out_free = !report_valid || report_ready;

  a_led_has_blink: assert property (@(posedge clk) disable iff (rst)
    led_on |-> blinks != '0)
    else $error("LED marked on with no blink counted");

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.report_load |=> report_valid && (blinks == '0) && (sample_index == '0))
    else $error("Report load did not present a result and clear the state");

  a_read_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> sample_index[lbcm_pkg::INDEX_W-1:lbcm_pkg::RING_AW] != '0)
    else $error("Ring read before the ring was filled");

  a_index_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(cmd.report_load) |-> sample_index >= $past(sample_index))
    else $error("Sample index went backwards without a finish");

endmodule
